>>> rtl/core/abf_pkg.sv
`default_nettype none

package abf_pkg;

    // fixed field widths
    localparam int ACT_W      = 2;
    localparam int PORT_W     = 3;
    localparam int TYPE_W     = 2;
    localparam int ID_W       = 16;
    localparam int WEIGHT_W   = 16;
    localparam int PCNT_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    // wide enough to compare a port number against any PORTS value up to 127
    localparam int PCMP_W     = 7;

    // actions
    localparam logic [ACT_W-1:0] ACT_MSG   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ROUND = 2'd2;

    // message types
    localparam logic [TYPE_W-1:0] T_EXPLORE   = 2'd0;
    localparam logic [TYPE_W-1:0] T_NONPARENT = 2'd1;
    localparam logic [TYPE_W-1:0] T_PARENT    = 2'd2;
    localparam logic [TYPE_W-1:0] T_TERMINATE = 2'd3;

    // port relations
    localparam logic [1:0] REL_NEIGHBOR = 2'd0;
    localparam logic [1:0] REL_PARENT   = 2'd1;
    localparam logic [1:0] REL_CHILD    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_COUNT = 2'd2;

    localparam logic [ID_W-1:0]   NODE_ID_RST    = 16'd1;
    localparam logic [PCNT_W-1:0] PORT_COUNT_RST = 4'd8;

    typedef struct packed {
        logic capture;  // latch the input beat
        logic exec;     // apply the step to node state and plan the sends
        logic emit;     // load the current slot into the output register
        logic advance;  // retire the current slot
    } cmd_t;

    typedef struct packed {
        logic hit;       // current slot has a beat to send
        logic final_slot; // nothing pending once this slot retires
        logic out_free;  // output register can take a beat
    } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/abf_ctrl.sv
`default_nettype none

module abf_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output abf_pkg::cmd_t      cmd,
    input  wire abf_pkg::sts_t sts
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        cmd.capture = s_tvalid && s_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // hold on a pending slot until the output register frees up
                cmd.emit    = sts.hit && sts.out_free;
                cmd.advance = !sts.hit || sts.out_free;
                if (cmd.advance && sts.final_slot)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/abf_dp.sv
`default_nettype none

module abf_dp
#(
    parameter int PORTS      = 8,
    parameter int DIST_WIDTH = 32,
    parameter int SEQ_WIDTH  = 16
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire abf_pkg::cmd_t                   cmd,
    output abf_pkg::sts_t                        sts,
    input  wire logic                            cfg_we,
    input  wire logic [abf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [abf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [abf_pkg::ACT_W-1:0]       action,
    input  wire logic [abf_pkg::PORT_W-1:0]      port,
    input  wire logic [abf_pkg::TYPE_W-1:0]      msg_type,
    input  wire logic [abf_pkg::ID_W-1:0]        sender_id,
    input  wire logic [SEQ_WIDTH-1:0]            msg_seq,
    input  wire logic [DIST_WIDTH-1:0]           msg_dist,
    input  wire logic [abf_pkg::WEIGHT_W-1:0]    link_weight,
    input  wire logic                            m_tready,
    output logic                                 out_valid,
    output logic                                 send_valid,
    output logic [abf_pkg::PORT_W-1:0]           out_port,
    output logic [abf_pkg::TYPE_W-1:0]           out_type,
    output logic [abf_pkg::ID_W-1:0]             out_sender,
    output logic [SEQ_WIDTH-1:0]                 out_seq,
    output logic [DIST_WIDTH-1:0]                out_dist,
    output logic                                 exited,
    output logic [abf_pkg::ID_W-1:0]             parent_node,
    output logic [DIST_WIDTH-1:0]                node_dist,
    output logic                                 last
);

    localparam int PW    = (PORTS > 1) ? $clog2(PORTS) : 1;
    // slots: one per port, then reject, parent notice, status only
    localparam int S_REJ  = PORTS;
    localparam int S_PAR  = PORTS + 1;
    localparam int S_STAT = PORTS + 2;
    localparam int SLOTS  = S_STAT + 1;
    localparam int SLW    = $clog2(SLOTS);
    localparam int SUM_W = ((DIST_WIDTH > abf_pkg::WEIGHT_W) ? DIST_WIDTH
                                                             : abf_pkg::WEIGHT_W) + 1;

    // configuration
    logic                         src_reg;
    logic [abf_pkg::ID_W-1:0]     node_id_reg;
    logic [abf_pkg::PCNT_W-1:0]   pcnt_reg;

    // captured input beat
    logic [abf_pkg::ACT_W-1:0]    in_act_reg;
    logic [abf_pkg::PORT_W-1:0]   in_port_reg;
    logic [abf_pkg::TYPE_W-1:0]   in_type_reg;
    logic [abf_pkg::ID_W-1:0]     in_sender_reg;
    logic [SEQ_WIDTH-1:0]         in_seq_reg;
    logic [DIST_WIDTH-1:0]        in_dist_reg;
    logic [abf_pkg::WEIGHT_W-1:0] in_wgt_reg;

    // node state
    logic [DIST_WIDTH-1:0]        best_reg,  best_next;
    logic                         pv_reg,    pv_next;
    logic [PW-1:0]                pport_reg, pport_next;
    logic [abf_pkg::ID_W-1:0]     pnode_reg, pnode_next;
    logic [SEQ_WIDTH-1:0]         eseq_reg,  eseq_next;
    logic [SEQ_WIDTH-1:0]         curr_reg,  curr_next;
    logic [PORTS-1:0]             acked_reg, acked_next;
    logic [1:0]                   rel_reg  [PORTS];
    logic [1:0]                   rel_next [PORTS];
    logic                         done_reg,  done_next;

    // send plan
    logic [SLOTS-1:0]             pend_reg,  pend_next;
    logic [SLW-1:0]               slot_reg,  slot_next;
    logic                         term_reg,  term_next;
    logic [PW-1:0]                rport_reg, rport_next;
    logic [SEQ_WIDTH-1:0]         rseq_reg,  rseq_next;

    // output register
    logic                         ov_reg;

    logic [PORTS-1:0]             use_mask;
    logic [PORTS-1:0]             child_mask;
    logic [PORTS-1:0]             p_bit;
    logic [PW-1:0]                p_idx;
    logic                         p_ok;
    logic [SUM_W-1:0]             sum;
    logic [DIST_WIDTH-1:0]        cand;
    logic [PORTS-1:0]             port_hits;
    logic                         rej_hit;
    logic                         par_check;
    logic                         par_hit;
    logic [SLOTS-1:0]             pend_clr;

    assign p_idx = PW'(in_port_reg);
    assign p_ok  = (abf_pkg::PCMP_W'(in_port_reg) < abf_pkg::PCMP_W'(PORTS))
                   && use_mask[p_idx];

    always_comb
    begin
        for (int i = 0; i < PORTS; i++)
        begin
            use_mask[i]   = abf_pkg::PCMP_W'(i) < abf_pkg::PCMP_W'(pcnt_reg);
            child_mask[i] = (rel_reg[i] == abf_pkg::REL_CHILD);
            p_bit[i]      = (p_idx == PW'(i));
        end
    end

    // saturating distance plus link weight
    assign sum  = SUM_W'(in_dist_reg) + SUM_W'(in_wgt_reg);
    assign cand = (sum > SUM_W'({DIST_WIDTH{1'b1}})) ? {DIST_WIDTH{1'b1}}
                                                      : sum[DIST_WIDTH-1:0];

    always_comb
    begin
        best_next  = best_reg;
        pv_next    = pv_reg;
        pport_next = pport_reg;
        pnode_next = pnode_reg;
        eseq_next  = eseq_reg;
        curr_next  = curr_reg;
        acked_next = acked_reg;
        rel_next   = rel_reg;
        done_next  = done_reg;
        pend_next  = pend_reg;
        slot_next  = slot_reg;
        term_next  = term_reg;
        rport_next = rport_reg;
        rseq_next  = rseq_reg;
        port_hits  = '0;
        rej_hit    = 1'b0;
        par_check  = 1'b0;
        par_hit    = 1'b0;
        pend_clr   = pend_reg;
        pend_clr[slot_reg] = 1'b0;

        if (cmd.exec)
        begin
            slot_next = '0;
            if (!done_reg)
            begin
                case (in_act_reg)
                    abf_pkg::ACT_MSG:
                    begin
                        if (p_ok)
                        begin
                            case (in_type_reg)
                                abf_pkg::T_EXPLORE:
                                begin
                                    par_check = 1'b1;
                                    if (cand < best_reg)
                                    begin
                                        best_next       = cand;
                                        pv_next         = 1'b1;
                                        pport_next      = p_idx;
                                        pnode_next      = in_sender_reg;
                                        curr_next       = in_seq_reg;
                                        rel_next[p_idx] = abf_pkg::REL_PARENT;
                                        eseq_next       = eseq_reg + 1'b1;
                                        acked_next      = p_bit;
                                        port_hits       = use_mask & ~p_bit;
                                        term_next       = 1'b0;
                                        // reject the old parent
                                        rej_hit         = pv_reg;
                                        rport_next      = pport_reg;
                                        rseq_next       = curr_reg;
                                    end
                                    else
                                    begin
                                        rej_hit    = 1'b1;
                                        rport_next = p_idx;
                                        rseq_next  = in_seq_reg;
                                    end
                                end
                                abf_pkg::T_NONPARENT, abf_pkg::T_PARENT:
                                begin
                                    par_check = 1'b1;
                                    if (in_seq_reg == eseq_reg)
                                    begin
                                        acked_next[p_idx] = 1'b1;
                                        rel_next[p_idx]   =
                                            (in_type_reg == abf_pkg::T_PARENT)
                                            ? abf_pkg::REL_CHILD : abf_pkg::REL_NEIGHBOR;
                                    end
                                end
                                default:
                                begin
                                    if (!src_reg && pv_reg && (pport_reg == p_idx))
                                    begin
                                        port_hits = use_mask & child_mask;
                                        term_next = 1'b1;
                                        done_next = 1'b1;
                                    end
                                    else
                                    begin
                                        par_check = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                    abf_pkg::ACT_START:
                    begin
                        if (src_reg)
                        begin
                            best_next  = '0;
                            eseq_next  = eseq_reg + 1'b1;
                            acked_next = '0;
                            if (pv_reg)
                            begin
                                acked_next[pport_reg] = 1'b1;
                            end
                            port_hits = use_mask;
                            term_next = 1'b0;
                        end
                    end
                    abf_pkg::ACT_ROUND:
                    begin
                        if (src_reg && (&(acked_reg | ~use_mask)))
                        begin
                            port_hits = use_mask & child_mask;
                            term_next = 1'b1;
                            done_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        port_hits = '0;
                    end
                endcase
            end
            par_hit = par_check && !src_reg && pv_next && (&(acked_next | ~use_mask));
            pend_next = {!(|port_hits) && !rej_hit && !par_hit, par_hit, rej_hit, port_hits};
        end
        else if (cmd.advance)
        begin
            pend_next = pend_clr;
            slot_next = slot_reg + 1'b1;
        end
    end

    assign sts.hit        = pend_reg[slot_reg];
    assign sts.final_slot = (pend_clr == '0);
    assign sts.out_free   = !ov_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg     <= 1'b0;
            node_id_reg <= abf_pkg::NODE_ID_RST;
            pcnt_reg    <= abf_pkg::PORT_COUNT_RST;
            best_reg    <= {DIST_WIDTH{1'b1}};
            pv_reg      <= 1'b0;
            pport_reg   <= '0;
            pnode_reg   <= '0;
            eseq_reg    <= '0;
            curr_reg    <= '0;
            acked_reg   <= '0;
            for (int i = 0; i < PORTS; i++)
            begin
                rel_reg[i] <= abf_pkg::REL_NEIGHBOR;
            end
            done_reg    <= 1'b0;
            pend_reg    <= '0;
            slot_reg    <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    abf_pkg::CFG_ROOT:       src_reg     <= cfg_data[0];
                    abf_pkg::CFG_NODE_ID:    node_id_reg <= cfg_data[abf_pkg::ID_W-1:0];
                    abf_pkg::CFG_PORT_COUNT: pcnt_reg    <= cfg_data[abf_pkg::PCNT_W-1:0];
                    default:                 src_reg     <= src_reg;
                endcase
            end
            best_reg  <= best_next;
            pv_reg    <= pv_next;
            pport_reg <= pport_next;
            pnode_reg <= pnode_next;
            eseq_reg  <= eseq_next;
            curr_reg  <= curr_next;
            acked_reg <= acked_next;
            rel_reg   <= rel_next;
            done_reg  <= done_next;
            pend_reg  <= pend_next;
            slot_reg  <= slot_next;
            if (cmd.emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_act_reg    <= action;
            in_port_reg   <= port;
            in_type_reg   <= msg_type;
            in_sender_reg <= sender_id;
            in_seq_reg    <= msg_seq;
            in_dist_reg   <= msg_dist;
            in_wgt_reg    <= link_weight;
        end
        term_reg  <= term_next;
        rport_reg <= rport_next;
        rseq_reg  <= rseq_next;
        if (cmd.emit)
        begin
            exited      <= done_reg;
            parent_node <= pnode_reg;
            node_dist   <= best_reg;
            last        <= sts.final_slot;
            if (slot_reg < SLW'(PORTS))
            begin
                send_valid <= 1'b1;
                out_port   <= abf_pkg::PORT_W'(slot_reg);
                out_type   <= term_reg ? abf_pkg::T_TERMINATE : abf_pkg::T_EXPLORE;
                out_sender <= node_id_reg;
                out_seq    <= term_reg ? '0 : eseq_reg;
                out_dist   <= term_reg ? '0 : best_reg;
            end
            else if (slot_reg == SLW'(S_REJ))
            begin
                send_valid <= 1'b1;
                out_port   <= abf_pkg::PORT_W'(rport_reg);
                out_type   <= abf_pkg::T_NONPARENT;
                out_sender <= node_id_reg;
                out_seq    <= rseq_reg;
                out_dist   <= '0;
            end
            else if (slot_reg == SLW'(S_PAR))
            begin
                send_valid <= 1'b1;
                out_port   <= abf_pkg::PORT_W'(pport_reg);
                out_type   <= abf_pkg::T_PARENT;
                out_sender <= node_id_reg;
                out_seq    <= curr_reg;
                out_dist   <= '0;
            end
            else
            begin
                // status only
                send_valid <= 1'b0;
                out_port   <= '0;
                out_type   <= abf_pkg::T_EXPLORE;
                out_sender <= '0;
                out_seq    <= '0;
                out_dist   <= '0;
            end
        end
    end

    assign out_valid = ov_reg;

endmodule

`default_nettype wire

>>> rtl/core/async_bellman_ford_node.sv
// One node of asynchronous distributed Bellman-Ford.
//
// s_* channel: one event per beat. s_tuser holds the action (message, source
// start, end-of-round check); s_tdata holds the received message and the weight
// of its link. cfg_* channel: register writes (root flag, node_id, port_count),
// always ready; the user must write only while the node is idle (not enforced).
// m_* channel: the messages the event sends, one per beat, in port order, then
// a reject, then a parent notice; an event that sends nothing gives a single
// status beat (m_tuser low). Every beat carries the node status after the event;
// m_tlast marks the final beat of an event.
//
// Timing: an event is captured when accepted and applied in the next cycle, then
// a scan visits one of the PORTS+3 send slots per cycle while the receiver keeps
// up, and stops after the last pending one; a status-only event scans all slots.
// A stalled receiver holds the output register and freezes the scan; the next
// event is accepted as soon as the scan is done, even with a beat still waiting.
// Reset: distance goes to infinity, no parent, all relations neighbor, node_id 1,
// port_count 8, not a root, output empty.
`default_nettype none

module async_bellman_ford_node
#(
    parameter int PORTS      = 8,
    parameter int DIST_WIDTH = 32,
    parameter int SEQ_WIDTH  = 16
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [abf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [abf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // port, msg_type, sender_id, msg_seq, msg_dist, link_weight
    input  wire logic [((37+SEQ_WIDTH+DIST_WIDTH+7)/8)*8-1:0] s_tdata,
    // action
    input  wire logic [abf_pkg::ACT_W-1:0]       s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // out_port, out_type, out_sender, out_seq, out_dist, exited, parent_node,
    // node_dist
    output logic [((38+SEQ_WIDTH+2*DIST_WIDTH+7)/8)*8-1:0] m_tdata,
    // send_valid
    output logic [0:0]                           m_tuser,
    output logic                                 m_tlast
);

    localparam int OUT_W   = ((38 + SEQ_WIDTH + 2*DIST_WIDTH + 7) / 8) * 8;
    localparam int I_SEQ   = 21;
    localparam int I_DIST  = I_SEQ + SEQ_WIDTH;
    localparam int I_WGT   = I_DIST + DIST_WIDTH;

    abf_pkg::cmd_t                 cmd;
    abf_pkg::sts_t                 sts;
    logic                          send_valid;
    logic [abf_pkg::PORT_W-1:0]    out_port;
    logic [abf_pkg::TYPE_W-1:0]    out_type;
    logic [abf_pkg::ID_W-1:0]      out_sender;
    logic [SEQ_WIDTH-1:0]          out_seq;
    logic [DIST_WIDTH-1:0]         out_dist;
    logic                          exited;
    logic [abf_pkg::ID_W-1:0]      parent_node;
    logic [DIST_WIDTH-1:0]         node_dist;

    assign cfg_ready = 1'b1;

    abf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    abf_dp
    #(
        .PORTS      (PORTS),
        .DIST_WIDTH (DIST_WIDTH),
        .SEQ_WIDTH  (SEQ_WIDTH)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .action      (s_tuser),
        .port        (s_tdata[2:0]),
        .msg_type    (s_tdata[4:3]),
        .sender_id   (s_tdata[20:5]),
        .msg_seq     (s_tdata[I_SEQ +: SEQ_WIDTH]),
        .msg_dist    (s_tdata[I_DIST +: DIST_WIDTH]),
        .link_weight (s_tdata[I_WGT +: abf_pkg::WEIGHT_W]),
        .m_tready    (m_tready),
        .out_valid   (m_tvalid),
        .send_valid  (send_valid),
        .out_port    (out_port),
        .out_type    (out_type),
        .out_sender  (out_sender),
        .out_seq     (out_seq),
        .out_dist    (out_dist),
        .exited      (exited),
        .parent_node (parent_node),
        .node_dist   (node_dist),
        .last        (m_tlast)
    );

    assign m_tdata = OUT_W'({node_dist, parent_node, exited, out_dist, out_seq,
                             out_sender, out_type, out_port});
    assign m_tuser = send_valid;

endmodule

`default_nettype wire

>>> rtl/core/abf_checker.sv
`default_nettype none

module abf_checker
#(
    parameter int DIST_WIDTH = 32,
    parameter int SEQ_WIDTH  = 16
)
(
    input wire logic                                               clk,
    input wire logic                                               rst_n,
    input wire logic                                               m_tvalid,
    input wire logic                                               m_tready,
    input wire logic [((38+SEQ_WIDTH+2*DIST_WIDTH+7)/8)*8-1:0]     m_tdata,
    input wire logic [0:0]                                         m_tuser,
    input wire logic                                               m_tlast
);

    localparam int O_EXIT = 21 + SEQ_WIDTH + DIST_WIDTH;

    logic seen_exit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_exit_reg <= 1'b0;
        end
        else if (m_tvalid && m_tready && m_tdata[O_EXIT])
        begin
            seen_exit_reg <= 1'b1;
        end
    end

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[20:0] == '0))
        else $error("status beat not alone or carries message fields");

    a_exit_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && seen_exit_reg |-> m_tdata[O_EXIT])
        else $error("node left the terminated state");

endmodule

bind async_bellman_ford_node abf_checker
#(
    .DIST_WIDTH (DIST_WIDTH),
    .SEQ_WIDTH  (SEQ_WIDTH)
)
u_abf_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

>>> verif/async_bellman_ford_node_tb.sv
module async_bellman_ford_node_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PORTS       = 8;
    localparam int S_W         = 88;
    localparam int M_W         = 120;
    localparam int LONG_STALL  = 300;
    localparam int CYCLE_LIMIT = 400000;
    // action code with no meaning to the node
    localparam logic [abf_pkg::ACT_W-1:0] ACT_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  port;
        logic [1:0]  kind;
        logic [15:0] sender;
        logic [15:0] seq;
        logic [31:0] offer_dist;
        logic [15:0] weight;
    } node_event_t;

    typedef struct packed {
        logic        send;
        logic [2:0]  port;
        logic [1:0]  kind;
        logic [15:0] sender;
        logic [15:0] seq;
        logic [31:0] sent_dist;
        logic        exited;
        logic [15:0] parent;
        logic [31:0] node_dist;
        logic        last;
    } out_beat_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [abf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [abf_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [S_W-1:0]                 s_tdata;
    logic [abf_pkg::ACT_W-1:0]      s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [M_W-1:0]                 m_tdata;
    logic [0:0]                     m_tuser;
    logic                           m_tlast;

    // node model state
    logic              src_mode;
    logic [15:0]       my_id;
    logic [3:0]        link_cnt;
    logic [31:0]       best_dist;
    logic              have_parent;
    logic [2:0]        up_port;
    logic [15:0]       up_node;
    logic [15:0]       wave_seq;
    logic [15:0]       prev_up_seq;
    logic [15:0]       up_seq;
    logic [PORTS-1:0]  acked;
    logic [1:0]        relation_of [PORTS];
    logic              node_done;

    out_beat_t step_sends[$];
    out_beat_t outgoing_msgs[$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  burst_left = 0;
    bit  hold_request = 1'b0;

    async_bellman_ford_node #(
        .PORTS(PORTS),
        .DIST_WIDTH(32),
        .SEQ_WIDTH(16)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- node model

    function automatic int ports_used();
        return (link_cnt > PORTS) ? PORTS : int'(link_cnt);
    endfunction

    function automatic bit every_port_acked();
        for (int i = 0; i < ports_used(); i++)
            if (!acked[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void start_wave();
        wave_seq = wave_seq + 16'd1;
        acked = '0;
        if (have_parent)
            acked[up_port] = 1'b1;
    endfunction

    function automatic void add_send(logic [1:0] kind, logic [2:0] port, logic [15:0] seq,
                                     logic [31:0] dist_val);
        out_beat_t b;
        b = '0;
        b.send = 1'b1;
        b.port = port;
        b.kind = kind;
        b.sender = my_id;
        b.seq = seq;
        b.sent_dist = dist_val;
        step_sends.push_back(b);
    endfunction

    function automatic void terminate_children();
        for (int i = 0; i < ports_used(); i++)
            if (relation_of[i] == abf_pkg::REL_CHILD)
                add_send(abf_pkg::T_TERMINATE, 3'(i), 16'd0, 32'd0);
        node_done = 1'b1;
    endfunction

    function automatic void take_message(node_event_t ev);
        logic [32:0] sum;
        logic [31:0] cand;
        logic        had;
        logic [2:0]  old_port;
        sum = {1'b0, ev.offer_dist} + {17'b0, ev.weight};
        cand = sum[32] ? 32'hffff_ffff : sum[31:0];
        case (ev.kind)
            abf_pkg::T_EXPLORE:
            begin
                if (cand < best_dist)
                begin
                    had = have_parent;
                    old_port = up_port;
                    best_dist = cand;
                    have_parent = 1'b1;
                    up_port = ev.port;
                    up_node = ev.sender;
                    prev_up_seq = up_seq;
                    up_seq = ev.seq;
                    relation_of[ev.port] = abf_pkg::REL_PARENT;
                    start_wave();
                    for (int i = 0; i < ports_used(); i++)
                        if (i != int'(ev.port))
                            add_send(abf_pkg::T_EXPLORE, 3'(i), wave_seq, best_dist);
                    if (had)
                        add_send(abf_pkg::T_NONPARENT, old_port, prev_up_seq, 32'd0);
                end
                else
                begin
                    add_send(abf_pkg::T_NONPARENT, ev.port, ev.seq, 32'd0);
                end
            end
            abf_pkg::T_NONPARENT, abf_pkg::T_PARENT:
            begin
                if (ev.seq == wave_seq)
                begin
                    acked[ev.port] = 1'b1;
                    relation_of[ev.port] = (ev.kind == abf_pkg::T_PARENT)
                                           ? abf_pkg::REL_CHILD : abf_pkg::REL_NEIGHBOR;
                end
            end
            default:
            begin
                if (!src_mode && have_parent && up_port == ev.port)
                begin
                    terminate_children();
                    return;
                end
            end
        endcase
        if (!src_mode && have_parent && every_port_acked())
            add_send(abf_pkg::T_PARENT, up_port, up_seq, 32'd0);
    endfunction

    function automatic void step_node(node_event_t ev);
        step_sends.delete();
        if (!node_done)
        begin
            case (ev.action)
                abf_pkg::ACT_MSG:
                    if (int'(ev.port) < ports_used())
                        take_message(ev);
                abf_pkg::ACT_START:
                    if (src_mode)
                    begin
                        best_dist = 32'd0;
                        start_wave();
                        for (int i = 0; i < ports_used(); i++)
                            add_send(abf_pkg::T_EXPLORE, 3'(i), wave_seq, best_dist);
                    end
                abf_pkg::ACT_ROUND:
                    if (src_mode && every_port_acked())
                        terminate_children();
                default:
                    ;
            endcase
        end
        if (step_sends.size() == 0)
            step_sends.push_back('0);
        foreach (step_sends[k])
        begin
            step_sends[k].exited = node_done;
            step_sends[k].parent = up_node;
            step_sends[k].node_dist = best_dist;
            step_sends[k].last = (k == step_sends.size() - 1);
            outgoing_msgs.push_back(step_sends[k]);
        end
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        out_beat_t got;
        out_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.send = m_tuser[0];
            got.port = m_tdata[2:0];
            got.kind = m_tdata[4:3];
            got.sender = m_tdata[20:5];
            got.seq = m_tdata[36:21];
            got.sent_dist = m_tdata[68:37];
            got.exited = m_tdata[69];
            got.parent = m_tdata[85:70];
            got.node_dist = m_tdata[117:86];
            got.last = m_tlast;
            if (outgoing_msgs.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: unexpected beat, expected none, got %h", $time, got);
            end
            else
            begin
                want = outgoing_msgs.pop_front();
                check_field("send_valid", want.send, got.send);
                check_field("out_port", want.port, got.port);
                check_field("out_type", want.kind, got.kind);
                check_field("out_sender", want.sender, got.sender);
                check_field("out_seq", want.seq, got.seq);
                check_field("out_dist", want.sent_dist, got.sent_dist);
                check_field("exited", want.exited, got.exited);
                check_field("parent_node", want.parent, got.parent);
                check_field("node_dist", want.node_dist, got.node_dist);
                check_field("last", want.last, got.last);
            end
        end
    end

    // receiver: changing stall patterns, plus one long hold-off on request
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_STALL;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic node_event_t msg_beat(logic [1:0] action, logic [2:0] port,
                                             logic [1:0] kind, logic [15:0] sender,
                                             logic [15:0] seq, logic [31:0] offer,
                                             logic [15:0] weight);
        node_event_t ev;
        ev.action = action;
        ev.port = port;
        ev.kind = kind;
        ev.sender = sender;
        ev.seq = seq;
        ev.offer_dist = offer;
        ev.weight = weight;
        return ev;
    endfunction

    function automatic node_event_t random_event();
        node_event_t ev;
        ev = msg_beat(abf_pkg::ACT_MSG, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                      16'($urandom), 16'($urandom), 32'($urandom), 16'($urandom));
        case ($urandom_range(0, 9))
            0: ev.action = 2'($urandom_range(1, 3));
            1: ev.offer_dist = 32'hffff_ffff;
            2, 3: ev.seq = wave_seq;
            default: ;
        endcase
        // keep the tree alive until the closing test
        if (ev.action == abf_pkg::ACT_ROUND && src_mode && every_port_acked())
            ev.action = abf_pkg::ACT_START;
        if (ev.action == abf_pkg::ACT_MSG && ev.kind == abf_pkg::T_TERMINATE && !src_mode &&
            have_parent && ev.port == up_port)
            ev.port = ev.port + 3'd1;
        return ev;
    endfunction

    function automatic node_event_t relax_explore();
        node_event_t ev;
        logic [31:0] room;
        ev = msg_beat(abf_pkg::ACT_MSG, 3'($urandom_range(0, 7)), abf_pkg::T_EXPLORE,
                      16'($urandom), 16'($urandom), 32'($urandom), 16'($urandom));
        if (ports_used() > 0)
            ev.port = 3'($urandom_range(0, ports_used() - 1));
        if (best_dist > {16'b0, ev.weight} + 32'd1)
        begin
            // land somewhat below the current best
            room = best_dist - {16'b0, ev.weight};
            ev.offer_dist = room - 32'd1 - (32'($urandom) % ((room >> 2) + 32'd1));
        end
        return ev;
    endfunction

    function automatic node_event_t ack_event(int port);
        return msg_beat(abf_pkg::ACT_MSG, 3'(port),
                        ($urandom_range(0, 1) != 0) ? abf_pkg::T_PARENT : abf_pkg::T_NONPARENT,
                        16'($urandom), wave_seq, 32'($urandom), 16'($urandom));
    endfunction

    task automatic send_event(input node_event_t ev);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            case ($urandom_range(0, 3))
                0: gap = 0;
                1, 2: gap = $urandom_range(1, 4);
                default: gap = $urandom_range(5, 24);
            endcase
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= ev.action;
        s_tdata <= {3'b0, ev.weight, ev.offer_dist, ev.seq, ev.sender, ev.kind, ev.port};
        do
            @(posedge clk);
        while (!s_tready);
        step_node(ev);
    endtask

    task automatic write_reg(input logic [abf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [abf_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            abf_pkg::CFG_ROOT: src_mode = value[0];
            abf_pkg::CFG_NODE_ID: my_id = value;
            abf_pkg::CFG_PORT_COUNT: link_cnt = value[3:0];
            default: ;
        endcase
    endtask

    // drain every pending beat, then let the scan settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (outgoing_msgs.size() != 0)
            @(posedge clk);
        repeat (PORTS + 8) @(posedge clk);
    endtask

    task automatic run_waves(input int count);
        int sent;
        int n;
        int j;
        int tmp;
        int order[PORTS];
        sent = 0;
        while (sent < count)
        begin
            n = ports_used();
            if (n == 0 || $urandom_range(0, 4) == 0)
            begin
                send_event(random_event());
                sent++;
            end
            else
            begin
                send_event(src_mode ? msg_beat(abf_pkg::ACT_START, 3'($urandom_range(0, 7)),
                                               2'($urandom), 16'($urandom), 16'($urandom),
                                               32'($urandom), 16'($urandom))
                                    : relax_explore());
                sent++;
                for (int i = 0; i < n; i++)
                    order[i] = i;
                for (int i = n - 1; i > 0; i--)
                begin
                    j = $urandom_range(0, i);
                    tmp = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        send_event(random_event());
                        sent++;
                    end
                    // leave a port silent now and then
                    if ($urandom_range(0, 9) != 0)
                    begin
                        send_event(ack_event(order[i]));
                        sent++;
                    end
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        send_event(msg_beat(ACT_NONE, 3'd0, abf_pkg::T_EXPLORE, 16'h0, 16'h0, 32'h0, 16'h0));
        send_event(msg_beat(abf_pkg::ACT_START, 3'd0, abf_pkg::T_EXPLORE, 16'h0, 16'h0, 32'h0,
                            16'h0));
        send_event(msg_beat(abf_pkg::ACT_ROUND, 3'd0, abf_pkg::T_EXPLORE, 16'h0, 16'h0, 32'h0,
                            16'h0));
        // ack before any parent: no notice
        send_event(msg_beat(abf_pkg::ACT_MSG, 3'd0, abf_pkg::T_NONPARENT, 16'h0, wave_seq,
                            32'h0, 16'h0));
        // saturating add, no relaxation
        send_event(msg_beat(abf_pkg::ACT_MSG, 3'd0, abf_pkg::T_EXPLORE, 16'hffff, 16'hffff,
                            32'hffff_ffff, 16'hffff));
        send_event(msg_beat(abf_pkg::ACT_MSG, 3'd7, abf_pkg::T_EXPLORE, 16'ha5a5, 16'h1234,
                            32'hfffe_0000, 16'hffff));
        send_event(msg_beat(abf_pkg::ACT_MSG, 3'd3, abf_pkg::T_TERMINATE, 16'h0, 16'h0, 32'h0,
                            16'h0));
        send_event(msg_beat(abf_pkg::ACT_MSG, 3'd0, abf_pkg::T_NONPARENT, 16'h0,
                            wave_seq - 16'd1, 32'h0, 16'h0));
        for (int i = 0; i < PORTS - 1; i++)
            send_event(msg_beat(abf_pkg::ACT_MSG, 3'(i),
                                (i == 1 || i == 2 || i == 5) ? abf_pkg::T_PARENT
                                                             : abf_pkg::T_NONPARENT,
                                16'(i), wave_seq, 32'h0, 16'h0));
        // better offer on the same parent port: reject goes back there
        send_event(msg_beat(abf_pkg::ACT_MSG, 3'd7, abf_pkg::T_EXPLORE, 16'h0, 16'h0,
                            32'h1000_0000, 16'h0));
        send_event(msg_beat(abf_pkg::ACT_MSG, 3'd2, abf_pkg::T_TERMINATE, 16'h0, 16'h0, 32'h0,
                            16'h0));
    endtask

    task automatic test_port_count();
        write_reg(abf_pkg::CFG_PORT_COUNT, 16'd3);
        send_event(msg_beat(abf_pkg::ACT_MSG, 3'd5, abf_pkg::T_EXPLORE, 16'h1, 16'h1, 32'h0,
                            16'h0));
        send_event(msg_beat(abf_pkg::ACT_MSG, 3'd1, abf_pkg::T_EXPLORE, 16'h0, 16'hffff,
                            32'hffff_ffff, 16'h0));
        for (int i = 0; i < 3; i++)
            send_event(ack_event(i));
        wait_idle();
        write_reg(abf_pkg::CFG_PORT_COUNT, 16'd0);
        send_event(msg_beat(abf_pkg::ACT_MSG, 3'd0, abf_pkg::T_EXPLORE, 16'h0, 16'h0, 32'h0,
                            16'h0));
        send_event(ack_event(0));
        wait_idle();
        write_reg(abf_pkg::CFG_PORT_COUNT, 16'd15);
        send_event(msg_beat(abf_pkg::ACT_MSG, 3'd7, abf_pkg::T_EXPLORE, 16'h7, 16'h7,
                            32'hffff_ffff, 16'h0));
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        run_waves(30);
    endtask

    task automatic test_source();
        write_reg(abf_pkg::CFG_ROOT, 16'd1);
        write_reg(abf_pkg::CFG_NODE_ID, 16'hffff);
        write_reg(abf_pkg::CFG_PORT_COUNT, 16'd8);
        send_event(msg_beat(abf_pkg::ACT_START, 3'd0, abf_pkg::T_EXPLORE, 16'h0, 16'h0, 32'h0,
                            16'h0));
        send_event(msg_beat(abf_pkg::ACT_START, 3'd7, abf_pkg::T_TERMINATE, 16'hffff,
                            16'hffff, 32'hffff_ffff, 16'hffff));
        send_event(msg_beat(abf_pkg::ACT_MSG, 3'd0, abf_pkg::T_EXPLORE, 16'h0, 16'h0, 32'h0,
                            16'h0));
        send_event(msg_beat(abf_pkg::ACT_MSG, up_port, abf_pkg::T_TERMINATE, 16'h0, 16'h0,
                            32'h0, 16'h0));
        send_event(msg_beat(abf_pkg::ACT_ROUND, 3'd0, abf_pkg::T_EXPLORE, 16'h0, 16'h0, 32'h0,
                            16'h0));
        run_waves(60);
    endtask

    task automatic test_termination();
        write_reg(abf_pkg::CFG_PORT_COUNT, 16'd8);
        if (have_parent && $urandom_range(0, 1) == 0)
        begin
            write_reg(abf_pkg::CFG_ROOT, 16'd0);
            for (int i = 0; i < PORTS; i++)
                if (i != int'(up_port) && $urandom_range(0, 1) != 0)
                    send_event(msg_beat(abf_pkg::ACT_MSG, 3'(i), abf_pkg::T_PARENT,
                                        16'($urandom), wave_seq, 32'($urandom),
                                        16'($urandom)));
            send_event(msg_beat(abf_pkg::ACT_MSG, up_port, abf_pkg::T_TERMINATE, up_node,
                                16'($urandom), 32'($urandom), 16'($urandom)));
        end
        else
        begin
            write_reg(abf_pkg::CFG_ROOT, 16'd1);
            send_event(msg_beat(abf_pkg::ACT_START, 3'd0, abf_pkg::T_EXPLORE, 16'h0, 16'h0,
                                32'h0, 16'h0));
            for (int i = 0; i < PORTS; i++)
                send_event(ack_event(i));
            send_event(msg_beat(abf_pkg::ACT_ROUND, 3'd0, abf_pkg::T_EXPLORE, 16'h0, 16'h0,
                                32'h0, 16'h0));
        end
        // everything after the tree closes is dropped
        for (int i = 0; i < 6; i++)
            send_event(random_event());
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        src_mode = 1'b0;
        my_id = abf_pkg::NODE_ID_RST;
        link_cnt = abf_pkg::PORT_COUNT_RST;
        best_dist = 32'hffff_ffff;
        have_parent = 1'b0;
        up_port = 3'd0;
        up_node = 16'd0;
        wave_seq = 16'd0;
        prev_up_seq = 16'd0;
        up_seq = 16'd0;
        acked = '0;
        node_done = 1'b0;
        for (int i = 0; i < PORTS; i++)
            relation_of[i] = abf_pkg::REL_NEIGHBOR;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        wait_idle();
        test_port_count();
        wait_idle();
        write_reg(abf_pkg::CFG_NODE_ID, 16'($urandom));
        write_reg(abf_pkg::CFG_PORT_COUNT, 16'd8);
        run_waves(90);
        wait_idle();
        write_reg(abf_pkg::CFG_PORT_COUNT, 16'd5);
        write_reg(abf_pkg::CFG_NODE_ID, 16'h0);
        run_waves(40);
        test_backpressure();
        wait_idle();
        test_source();
        wait_idle();
        test_termination();
        wait_idle();

        if (mismatch_count == 0 && outgoing_msgs.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
